// ===== design/i2c_master_byte_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CMBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/i2cmbs_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer package
// Item types, operation codes and phase codes shared by the sequencer files.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

  typedef enum logic {
    REQ_CMD  = 1'b0,
    REQ_TICK = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_LAST   = 2'd2
  } phase_e;

  localparam logic [3:0] BitsPerByte    = 4'd8;
  localparam logic [7:0] AckTimeoutRst  = 8'd250;

  typedef struct packed {
    logic       req_type;
    logic [1:0] command;
    logic [7:0] write_data;
    logic       send_ack;
    logic [1:0] port;
    logic       sda_in;
  } i2cmbs_in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic [1:0] port_out;
    logic [7:0] read_data;
    logic       ack_failed;
    logic       done_res;
    logic       busy_res;
  } i2cmbs_out_t;

endpackage

// ===== design/i2c_master_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Each accepted item's result item is registered and appears in the cycle after.
// Throughput: one item per cycle while the receiver takes results; the result register is the only stage.
// Reset: idle, SCL and SDA high and driven, timeout 250, read byte zero.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer import i2cmbs_pkg::*; #(
  parameter int NUM_PORTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  i2cmbs_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output i2cmbs_out_t out_data_o
);

  localparam logic [1:0] MaxPort = 2'(NUM_PORTS - 1);

  logic       busy_q, busy_d;
  op_e        op_q, op_d;
  phase_e     phase_q, phase_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] wait_q, wait_d;
  logic [1:0] port_q, port_d;
  logic       ack_q, ack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  logic       drv_q, drv_d;
  logic [7:0] last_read_q, last_read_d;
  logic       fail_q, fail_d;
  logic [7:0] timeout_q;
  logic       done;
  logic [1:0] sel_port;

  logic        out_valid_q;
  i2cmbs_out_t out_q, out_d;
  logic        in_acc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (int'(in_data_i.port) > NUM_PORTS - 1) begin
      sel_port = MaxPort;
    end else begin
      sel_port = in_data_i.port;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    op_d        = op_q;
    phase_d     = phase_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    wait_d      = wait_q;
    port_d      = port_q;
    ack_d       = ack_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    drv_d       = drv_q;
    last_read_d = last_read_q;
    fail_d      = fail_q;
    done        = 1'b0;

    if (in_data_i.req_type == REQ_CMD) begin
      if (!busy_q) begin
        busy_d  = 1'b1;
        op_d    = op_e'(in_data_i.command);
        port_d  = sel_port;
        shift_d = (op_e'(in_data_i.command) == OP_READ) ? 8'd0 : in_data_i.write_data;
        ack_d   = in_data_i.send_ack;
        phase_d = PH_FIRST;
        bit_d   = 4'd0;
        wait_d  = 8'd0;
        fail_d  = 1'b0;
      end
    end else if (busy_q) begin
      case (op_q)
        OP_START: begin
          if (phase_q == PH_FIRST) begin
            {scl_d, sda_d, drv_d} = 3'b111;
            phase_d = PH_SECOND;
          end else if (phase_q == PH_SECOND) begin
            {scl_d, sda_d, drv_d} = 3'b101;
            phase_d = PH_LAST;
          end else begin
            {scl_d, sda_d, drv_d} = 3'b001;
            done = 1'b1;
          end
        end
        OP_STOP: begin
          if (phase_q == PH_FIRST) begin
            {scl_d, sda_d, drv_d} = 3'b001;
            phase_d = PH_SECOND;
          end else if (phase_q == PH_SECOND) begin
            {scl_d, sda_d, drv_d} = 3'b101;
            phase_d = PH_LAST;
          end else begin
            {scl_d, sda_d, drv_d} = 3'b111;
            done = 1'b1;
          end
        end
        OP_WRITE: begin
          if (bit_q < BitsPerByte) begin
            if (phase_q == PH_FIRST) begin
              {scl_d, sda_d, drv_d} = {1'b0, shift_q[7], 1'b1};
              phase_d = PH_SECOND;
            end else begin
              scl_d   = 1'b1;
              drv_d   = 1'b1;
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 4'd1;
              phase_d = PH_FIRST;
            end
          end else if (phase_q == PH_FIRST) begin
            {scl_d, sda_d, drv_d} = 3'b010;
            phase_d = PH_SECOND;
          end else if (phase_q == PH_SECOND) begin
            {scl_d, sda_d, drv_d} = 3'b110;
            phase_d = PH_LAST;
          end else if (!in_data_i.sda_in) begin
            {scl_d, sda_d, drv_d} = 3'b010;
            done = 1'b1;
          end else if (wait_q >= timeout_q) begin
            // no ACK in time: fall into the stop sequence
            fail_d  = 1'b1;
            op_d    = OP_STOP;
            {scl_d, sda_d, drv_d} = 3'b001;
            phase_d = PH_SECOND;
          end else begin
            wait_d = wait_q + 8'd1;
          end
        end
        OP_READ: begin
          if (bit_q < BitsPerByte) begin
            if (phase_q == PH_FIRST) begin
              {scl_d, sda_d, drv_d} = 3'b010;
              phase_d = PH_SECOND;
            end else begin
              {scl_d, sda_d, drv_d} = 3'b110;
              shift_d = {shift_q[6:0], in_data_i.sda_in};
              bit_d   = bit_q + 4'd1;
              phase_d = PH_FIRST;
            end
          end else if (phase_q == PH_FIRST) begin
            {scl_d, sda_d, drv_d} = {1'b0, !ack_q, 1'b1};
            phase_d = PH_SECOND;
          end else if (phase_q == PH_SECOND) begin
            scl_d = 1'b1;
            drv_d = 1'b1;
            phase_d = PH_LAST;
          end else begin
            scl_d       = 1'b0;
            drv_d       = 1'b1;
            last_read_d = shift_q;
            done        = 1'b1;
          end
        end
        default: begin
          done = 1'b0;
        end
      endcase
      if (done) begin
        busy_d  = 1'b0;
        phase_d = PH_FIRST;
        bit_d   = 4'd0;
      end
    end
  end

  always_comb begin
    out_d.scl_level  = scl_d;
    out_d.sda_level  = sda_d;
    out_d.sda_drive  = drv_d;
    out_d.port_out   = port_d;
    out_d.read_data  = last_read_d;
    out_d.ack_failed = fail_d;
    out_d.done_res   = done;
    out_d.busy_res   = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      op_q        <= OP_START;
      phase_q     <= PH_FIRST;
      bit_q       <= 4'd0;
      shift_q     <= 8'd0;
      wait_q      <= 8'd0;
      port_q      <= 2'd0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      last_read_q <= 8'd0;
      fail_q      <= 1'b0;
      timeout_q   <= AckTimeoutRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        busy_q      <= busy_d;
        op_q        <= op_d;
        phase_q     <= phase_d;
        bit_q       <= bit_d;
        shift_q     <= shift_d;
        wait_q      <= wait_d;
        port_q      <= port_d;
        ack_q       <= ack_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        drv_q       <= drv_d;
        last_read_q <= last_read_d;
        fail_q      <= fail_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

endmodule

// ===== design/i2cmbs_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer checker
// Port-level assertions on item flow and line behavior, bound to the top.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_sequencer_macros.svh"

module i2cmbs_checker import i2cmbs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input i2cmbs_out_t out_data_o
);

  `I2CMBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result item dropped while stalled")
  `I2CMBS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o), "stalled result item changed")
  `I2CMBS_ASSERT_IMPL(a_no_overrun, clk_i, rst_ni, in_ready_o, !out_valid_o || out_ready_i, "item accepted over a stalled result")
  `I2CMBS_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_valid_i && in_ready_o, out_valid_o, "accepted item gave no result")
  `I2CMBS_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, out_valid_o && out_data_o.done_res, !out_data_o.busy_res && out_data_o.sda_drive == (out_data_o.scl_level || !out_data_o.sda_level || out_data_o.sda_drive), "completion while busy")

endmodule

bind i2c_master_byte_sequencer i2cmbs_checker u_i2cmbs_checker (.*);

// ===== sim/tb_i2c_master_byte_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master byte sequencer testbench
// Sends command and tick items through a queue-fed driver. Each accepted item
// runs through a bus-line predictor. A monitor checks every result item
// against the oldest prediction. The ACK timeout is changed between phases
// while the block is idle. Random gaps on both sides, plus one long receiver
// hold-off, put back-pressure on the input.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbs_pkg::*;

  localparam int NumPorts  = 4;
  localparam int PhaseLen  = 350;
  localparam int InWidth   = $bits(i2cmbs_in_t);

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'd0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  i2cmbs_in_t  in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  i2cmbs_out_t out_data_o;

  i2c_master_byte_sequencer #(.NUM_PORTS(NumPorts)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // bus items waiting to be sent, predicted line states waiting to come back
  i2cmbs_in_t  bus_items[$];
  i2cmbs_out_t line_expect[$];

  // predicted sequencer state
  logic [7:0] ack_limit = AckTimeoutRst;
  logic       seq_busy;
  op_e        seq_op;
  phase_e     seq_phase;
  logic [3:0] seq_bits;
  logic [7:0] seq_shift;
  logic [7:0] seq_wait;
  logic [1:0] seq_port;
  logic       seq_ack;
  logic       line_scl, line_sda, line_drv;
  logic [7:0] seq_last_read;
  logic       seq_failed;

  logic        calm         = 1'b0;
  int          send_pause   = 0;
  int          recv_pause   = 0;
  int          results_seen = 0;
  int          hold_left    = 0;
  logic        held         = 1'b0;
  int          fault_count  = 0;
  i2cmbs_out_t want;

  function automatic i2cmbs_out_t step_bus(i2cmbs_in_t it);
    i2cmbs_out_t res;
    logic        done;
    done = 1'b0;
    if (it.req_type == REQ_CMD) begin
      if (!seq_busy) begin
        seq_busy   = 1'b1;
        seq_op     = op_e'(it.command);
        seq_port   = (int'(it.port) > NumPorts - 1) ? 2'(NumPorts - 1) : it.port;
        seq_shift  = (seq_op == OP_READ) ? 8'd0 : it.write_data;
        seq_ack    = it.send_ack;
        seq_phase  = PH_FIRST;
        seq_bits   = '0;
        seq_wait   = '0;
        seq_failed = 1'b0;
      end
    end else if (seq_busy) begin
      case (seq_op)
        OP_START: begin
          if (seq_phase == PH_FIRST) begin
            {line_scl, line_sda, line_drv} = 3'b111;
            seq_phase = PH_SECOND;
          end else if (seq_phase == PH_SECOND) begin
            {line_scl, line_sda, line_drv} = 3'b101;
            seq_phase = PH_LAST;
          end else begin
            {line_scl, line_sda, line_drv} = 3'b001;
            done = 1'b1;
          end
        end
        OP_STOP: begin
          if (seq_phase == PH_FIRST) begin
            {line_scl, line_sda, line_drv} = 3'b001;
            seq_phase = PH_SECOND;
          end else if (seq_phase == PH_SECOND) begin
            {line_scl, line_sda, line_drv} = 3'b101;
            seq_phase = PH_LAST;
          end else begin
            {line_scl, line_sda, line_drv} = 3'b111;
            done = 1'b1;
          end
        end
        OP_WRITE: begin
          if (seq_bits < BitsPerByte) begin
            if (seq_phase == PH_FIRST) begin
              {line_scl, line_sda, line_drv} = {1'b0, seq_shift[7], 1'b1};
              seq_phase = PH_SECOND;
            end else begin
              {line_scl, line_drv} = 2'b11;
              seq_shift = {seq_shift[6:0], 1'b0};
              seq_bits  = seq_bits + 4'd1;
              seq_phase = PH_FIRST;
            end
          end else if (seq_phase == PH_FIRST) begin
            {line_scl, line_sda, line_drv} = 3'b010;
            seq_phase = PH_SECOND;
          end else if (seq_phase == PH_SECOND) begin
            {line_scl, line_sda, line_drv} = 3'b110;
            seq_phase = PH_LAST;
          end else if (!it.sda_in) begin
            {line_scl, line_sda, line_drv} = 3'b010;
            done = 1'b1;
          end else if (seq_wait >= ack_limit) begin
            // no ACK in time: fall into the stop sequence
            seq_failed = 1'b1;
            seq_op     = OP_STOP;
            {line_scl, line_sda, line_drv} = 3'b001;
            seq_phase  = PH_SECOND;
          end else begin
            seq_wait = seq_wait + 8'd1;
          end
        end
        default: begin
          if (seq_bits < BitsPerByte) begin
            if (seq_phase == PH_FIRST) begin
              {line_scl, line_sda, line_drv} = 3'b010;
              seq_phase = PH_SECOND;
            end else begin
              {line_scl, line_sda, line_drv} = 3'b110;
              seq_shift = {seq_shift[6:0], it.sda_in};
              seq_bits  = seq_bits + 4'd1;
              seq_phase = PH_FIRST;
            end
          end else if (seq_phase == PH_FIRST) begin
            {line_scl, line_sda, line_drv} = {1'b0, !seq_ack, 1'b1};
            seq_phase = PH_SECOND;
          end else if (seq_phase == PH_SECOND) begin
            {line_scl, line_drv} = 2'b11;
            seq_phase = PH_LAST;
          end else begin
            {line_scl, line_drv} = 2'b01;
            seq_last_read = seq_shift;
            done = 1'b1;
          end
        end
      endcase
      if (done) begin
        seq_busy  = 1'b0;
        seq_phase = PH_FIRST;
        seq_bits  = '0;
      end
    end
    res.scl_level  = line_scl;
    res.sda_level  = line_sda;
    res.sda_drive  = line_drv;
    res.port_out   = seq_port;
    res.read_data  = seq_last_read;
    res.ack_failed = seq_failed;
    res.done_res   = done;
    res.busy_res   = seq_busy;
    return res;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic i2cmbs_in_t any_item();
    logic [InWidth-1:0] raw;
    raw = InWidth'($urandom);
    return raw;
  endfunction

  function automatic i2cmbs_in_t make_item(req_e req, op_e op, logic [7:0] wd,
                                           logic ack, logic [1:0] prt, logic sda);
    i2cmbs_in_t it;
    it.req_type   = req;
    it.command    = op;
    it.write_data = wd;
    it.send_ack   = ack;
    it.port       = prt;
    it.sda_in     = sda;
    return it;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  // tick during an operation; now and then a command that the busy block drops
  task automatic add_tick(input logic sda, inout int n);
    i2cmbs_in_t it;
    if ($urandom_range(0, 99) < 4) begin
      it = any_item();
      it.req_type = REQ_CMD;
      bus_items.push_back(it);
    end
    it = any_item();
    it.req_type = REQ_TICK;
    it.sda_in   = sda;
    bus_items.push_back(it);
    n++;
  endtask

  task automatic add_operation(inout int n);
    i2cmbs_in_t it;
    op_e        op;
    logic [7:0] rd_byte;
    int         highs;
    op = op_e'($urandom_range(0, 3));
    it = any_item();
    it.req_type   = REQ_CMD;
    it.command    = op;
    it.write_data = pick_byte();
    bus_items.push_back(it);
    n++;
    case (op)
      OP_START, OP_STOP: begin
        repeat (3) add_tick(1'($urandom), n);
      end
      OP_READ: begin
        rd_byte = pick_byte();
        for (int b = 7; b >= 0; b--) begin
          add_tick(1'($urandom), n);
          add_tick(rd_byte[b], n);
        end
        repeat (3) add_tick(1'($urandom), n);
      end
      default: begin
        repeat (18) add_tick(1'($urandom), n);
        if ($urandom_range(0, 99) < ((ack_limit < 16) ? 15 : 4)) begin
          repeat (int'(ack_limit) + 1) add_tick(1'b1, n);
          repeat (2) add_tick(1'($urandom), n);
        end else begin
          if ($urandom_range(0, 3) == 0) highs = $urandom_range(0, ack_limit);
          else highs = $urandom_range(0, (ack_limit < 4) ? ack_limit : 4);
          repeat (highs) add_tick(1'b1, n);
          add_tick(1'b0, n);
        end
      end
    endcase
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 2)) begin
        it = any_item();
        it.req_type = REQ_TICK;
        bus_items.push_back(it);
      end
    end
  endtask

  task automatic wait_idle();
    while (bus_items.size() != 0 || in_valid_i || line_expect.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_timeout(input logic [7:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    ack_limit    = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) line_expect.push_back(step_bus(in_data_i));
      if (!in_valid_i || in_ready_o) begin
        if (send_pause > 0) begin
          send_pause--;
          in_valid_i <= 1'b0;
        end else if (bus_items.size() > 0) begin
          in_data_i  <= bus_items.pop_front();
          in_valid_i <= 1'b1;
          send_pause  = pause_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!held && results_seen >= 300) begin
        hold_left <= 400;
        held      <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (line_expect.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("result item with none expected: %p", out_data_o);
        end else begin
          want = line_expect.pop_front();
          if (out_data_o.scl_level !== want.scl_level ||
              out_data_o.sda_level !== want.sda_level ||
              out_data_o.sda_drive !== want.sda_drive ||
              out_data_o.port_out !== want.port_out ||
              out_data_o.read_data !== want.read_data ||
              out_data_o.ack_failed !== want.ack_failed ||
              out_data_o.done_res !== want.done_res ||
              out_data_o.busy_res !== want.busy_res) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display("mismatch at %0t: expected %p", $realtime, want);
              $display("                 actual   %p", out_data_o);
            end
          end
        end
      end
      if (recv_pause > 0) begin
        recv_pause--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (hold_left == 0);
        if (out_valid_o && out_ready_i) recv_pause = pause_len();
      end
    end
  end

  initial begin
    logic [7:0] limits[5];
    int         counted;
    seq_busy      = 1'b0;
    seq_op        = OP_START;
    seq_phase     = PH_FIRST;
    seq_bits      = '0;
    seq_shift     = '0;
    seq_wait      = '0;
    seq_port      = '0;
    seq_ack       = 1'b0;
    {line_scl, line_sda, line_drv} = 3'b111;
    seq_last_read = '0;
    seq_failed    = 1'b0;
    ack_limit     = AckTimeoutRst;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // idle tick, start with an ignored command, stop, idle tick
    bus_items.push_back(make_item(REQ_TICK, OP_READ, 8'hFF, 1'b1, 2'd3, 1'b1));
    bus_items.push_back(make_item(REQ_CMD, OP_START, 8'hFF, 1'b1, 2'd3, 1'b1));
    bus_items.push_back(make_item(REQ_CMD, OP_WRITE, 8'h00, 1'b0, 2'd0, 1'b0));
    bus_items.push_back(make_item(REQ_TICK, OP_START, 8'h00, 1'b0, 2'd0, 1'b0));
    bus_items.push_back(make_item(REQ_TICK, OP_STOP, 8'hFF, 1'b1, 2'd3, 1'b1));
    bus_items.push_back(make_item(REQ_TICK, OP_WRITE, 8'h5A, 1'b0, 2'd1, 1'b0));
    bus_items.push_back(make_item(REQ_CMD, OP_STOP, 8'h00, 1'b0, 2'd0, 1'b0));
    bus_items.push_back(make_item(REQ_TICK, OP_START, 8'hFF, 1'b1, 2'd2, 1'b1));
    bus_items.push_back(make_item(REQ_TICK, OP_READ, 8'hA5, 1'b0, 2'd1, 1'b0));
    bus_items.push_back(make_item(REQ_TICK, OP_STOP, 8'h00, 1'b1, 2'd3, 1'b1));
    bus_items.push_back(make_item(REQ_TICK, OP_WRITE, 8'hFF, 1'b0, 2'd0, 1'b0));

    limits = '{8'd1, 8'd255, 8'd0, 8'd0, 8'd128};
    limits[3] = 8'($urandom_range(2, 254));
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      set_timeout(limits[p]);
      calm = (p == 3);
      counted = 0;
      while (counted < PhaseLen) add_operation(counted);
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (fault_count == 0 && line_expect.size() == 0) begin
      $display("tb_i2c_master_byte_sequencer: PASS");
    end else begin
      $display("tb_i2c_master_byte_sequencer: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_i2c_master_byte_sequencer: FAIL");
    $finish;
  end

endmodule
